>>> hw/rtl/etr_pkg.sv
// Shared types, widths and codes for the event trace ring buffer.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package etr_pkg;

  localparam int TIME_W     = 32;
  localparam int EVENT_W    = 16;
  localparam int PARAM_W    = 32;
  localparam int REMAIN_W   = 8;
  localparam int LOST_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int RING_DEPTH_DEF = 256;

  localparam logic [LOST_W-1:0]  LOST_MAX           = {LOST_W{1'b1}};
  localparam logic [EVENT_W-1:0] OVERWR_CODE_RESET  = 16'd1;

  // Command field of an input request.
  localparam logic CMD_LOG  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_OFFSET = 2'd0,
    CFG_WRAP_CODE   = 2'd1,
    CFG_OVERWR_CODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_WRAP,
    ST_WR_EVENT,
    ST_RD_RESULT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]  ts;
    logic [EVENT_W-1:0] code;
    logic [PARAM_W-1:0] param;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic write_wrap;
    logic write_event;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic new_is_read;
    logic new_wrap;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/etr_item_if.sv
// Input request channel of the event trace ring buffer.
// Depends on etr_pkg for field widths.
`default_nettype none

interface etr_item_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [etr_pkg::TIME_W-1:0]        raw_time;
  logic [etr_pkg::EVENT_W-1:0]       event_code;
  logic signed [etr_pkg::PARAM_W-1:0] event_param;

  modport source (output valid, cmd, raw_time, event_code, event_param, input ready);
  modport sink   (input valid, cmd, raw_time, event_code, event_param, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/etr_result_if.sv
// Result channel of the event trace ring buffer.
// Depends on etr_pkg for field widths.
`default_nettype none

interface etr_result_if;
  logic                               valid;
  logic                               ready;
  logic [etr_pkg::TIME_W-1:0]         out_timestamp;
  logic [etr_pkg::EVENT_W-1:0]        out_event;
  logic signed [etr_pkg::PARAM_W-1:0] out_param;
  logic                               out_empty;
  logic [etr_pkg::REMAIN_W-1:0]       out_remaining;

  modport source (output valid, out_timestamp, out_event, out_param, out_empty,
                  out_remaining, input ready);
  modport sink   (input valid, out_timestamp, out_event, out_param, out_empty,
                  out_remaining, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/etr_cfg_if.sv
// Register write channel of the event trace ring buffer.
// Depends on etr_pkg for index and data widths.
`default_nettype none

interface etr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [etr_pkg::CFG_IDX_W-1:0]    index;
  logic [etr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/etr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
`default_nettype none

module etr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/etr_ctrl.sv
// Sequencing state machine of the event trace ring buffer.
// Depends on etr_pkg for the state type and the command and status structs.
`default_nettype none

module etr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire etr_pkg::dp_status_t status,
  output etr_pkg::ctrl_cmd_t       cmd
);

  etr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      etr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.new_is_read) begin
            state_next = etr_pkg::ST_RD_RESULT;
          end else if (status.new_wrap) begin
            state_next = etr_pkg::ST_WR_WRAP;
          end else begin
            state_next = etr_pkg::ST_WR_EVENT;
          end
        end
      end
      etr_pkg::ST_WR_WRAP:   state_next = etr_pkg::ST_WR_EVENT;
      etr_pkg::ST_WR_EVENT:  state_next = etr_pkg::ST_IDLE;
      etr_pkg::ST_RD_RESULT: begin
        if (status.out_free) begin
          state_next = etr_pkg::ST_IDLE;
        end
      end
      default: state_next = etr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.write_wrap  = 1'b0;
    cmd.write_event = 1'b0;
    cmd.emit        = 1'b0;
    case (state)
      etr_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      etr_pkg::ST_WR_WRAP:   cmd.write_wrap  = 1'b1;
      etr_pkg::ST_WR_EVENT:  cmd.write_event = 1'b1;
      etr_pkg::ST_RD_RESULT: cmd.emit        = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A wrap entry is always followed by the event entry of the same request.
  assert property (@(posedge clk) disable iff (rst)
    state == etr_pkg::ST_WR_WRAP |=> state == etr_pkg::ST_WR_EVENT)
    else $error("wrap entry not followed by event entry");

endmodule

`default_nettype wire

>>> hw/rtl/etr_datapath.sv
// Datapath of the event trace ring buffer: registers, ring indices, counters,
// entry RAM and output register. Depends on etr_pkg and etr_ram.
`default_nettype none

module etr_datapath #(
  parameter int RING_DEPTH = etr_pkg::RING_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input request payload
  input  wire logic                               in_cmd,
  input  wire logic [etr_pkg::TIME_W-1:0]         in_raw_time,
  input  wire logic [etr_pkg::EVENT_W-1:0]        in_event_code,
  input  wire logic signed [etr_pkg::PARAM_W-1:0] in_event_param,
  // Register writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [etr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [etr_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [etr_pkg::TIME_W-1:0]              out_timestamp,
  output logic [etr_pkg::EVENT_W-1:0]             out_event,
  output logic signed [etr_pkg::PARAM_W-1:0]      out_param,
  output logic                                    out_empty,
  output logic [etr_pkg::REMAIN_W-1:0]            out_remaining,
  // Control
  input  wire etr_pkg::ctrl_cmd_t                 cmd,
  output etr_pkg::dp_status_t                     status
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = IDX_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  // Configuration registers
  logic [etr_pkg::TIME_W-1:0]  time_offset;
  logic [etr_pkg::EVENT_W-1:0] wrap_code;
  logic [etr_pkg::EVENT_W-1:0] overwr_code;

  // Ring state
  logic [IDX_W-1:0]            write_index;
  logic [IDX_W-1:0]            read_index;
  logic [CNT_W-1:0]            item_count;
  logic [etr_pkg::LOST_W-1:0]  lost_count;
  logic [etr_pkg::TIME_W-1:0]  last_time;

  // Latched log request
  logic [etr_pkg::TIME_W-1:0]  item_ts;
  logic [etr_pkg::EVENT_W-1:0] item_code;
  logic [etr_pkg::PARAM_W-1:0] item_param;

  logic [etr_pkg::TIME_W-1:0]  ts_sum;
  logic                        ram_we;
  etr_pkg::entry_t             wr_entry;
  etr_pkg::entry_t             rd_entry;
  logic [IDX_W-1:0]            write_index_step;
  logic                        overrun;
  logic                        ring_empty;
  logic                        have_lost;
  logic [CNT_W-1:0]            count_dec;
  logic [CNT_W+etr_pkg::REMAIN_W-1:0] count_ext;
  logic [CNT_W+etr_pkg::REMAIN_W-1:0] count_dec_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_offset <= '0;
      wrap_code   <= '0;
      overwr_code <= etr_pkg::OVERWR_CODE_RESET;
    end else if (cfg_valid) begin
      case (etr_pkg::cfg_reg_t'(cfg_index))
        etr_pkg::CFG_TIME_OFFSET: time_offset <= cfg_data[etr_pkg::TIME_W-1:0];
        etr_pkg::CFG_WRAP_CODE:   wrap_code   <= cfg_data[etr_pkg::EVENT_W-1:0];
        etr_pkg::CFG_OVERWR_CODE: overwr_code <= cfg_data[etr_pkg::EVENT_W-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  assign ts_sum = in_raw_time + time_offset;

  assign status.new_is_read = (in_cmd == etr_pkg::CMD_READ);
  assign status.new_wrap    = (ts_sum < last_time);
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_ts    <= ts_sum;
      item_code  <= in_event_code;
      item_param <= in_event_param;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (cmd.accept && in_cmd == etr_pkg::CMD_LOG) begin
      last_time <= ts_sum;
    end
  end

  // Entry write. A wrap entry carries its own timestamp as the parameter.
  assign ram_we         = cmd.write_wrap || cmd.write_event;
  assign wr_entry.ts    = item_ts;
  assign wr_entry.code  = cmd.write_wrap ? wrap_code : item_code;
  assign wr_entry.param = cmd.write_wrap ? item_ts : item_param;

  etr_ram #(
    .WIDTH ($bits(etr_pkg::entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (wr_entry),
    .raddr (read_index),
    .rdata (rd_entry)
  );

  assign write_index_step = next_slot(write_index);
  assign overrun          = (write_index_step == read_index);
  assign ring_empty       = (read_index == write_index);
  assign have_lost        = (lost_count != '0);
  assign count_dec        = (item_count != '0) ? item_count - 1'b1 : item_count;
  assign count_ext        = {{etr_pkg::REMAIN_W{1'b0}}, item_count};
  assign count_dec_ext    = {{etr_pkg::REMAIN_W{1'b0}}, count_dec};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      item_count  <= '0;
      lost_count  <= '0;
    end else if (ram_we) begin
      write_index <= write_index_step;
      if (overrun) begin
        // The oldest entry is dropped to make room.
        read_index <= next_slot(read_index);
        if (lost_count != etr_pkg::LOST_MAX) begin
          lost_count <= lost_count + 1'b1;
        end
      end else begin
        item_count <= item_count + 1'b1;
      end
    end else if (cmd.emit && !ring_empty) begin
      if (have_lost) begin
        lost_count <= '0;
      end else begin
        read_index <= next_slot(read_index);
        item_count <= count_dec;
      end
    end
  end

  // Output register; the RAM read data is stable while the result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (ring_empty) begin
        out_timestamp <= '0;
        out_event     <= '0;
        out_param     <= '0;
        out_empty     <= 1'b1;
        out_remaining <= count_ext[etr_pkg::REMAIN_W-1:0];
      end else if (have_lost) begin
        out_timestamp <= rd_entry.ts;
        out_event     <= overwr_code;
        out_param     <= $signed({1'b0, lost_count});
        out_empty     <= 1'b0;
        out_remaining <= count_ext[etr_pkg::REMAIN_W-1:0];
      end else begin
        out_timestamp <= rd_entry.ts;
        out_event     <= rd_entry.code;
        out_param     <= $signed(rd_entry.param);
        out_empty     <= 1'b0;
        out_remaining <= count_dec_ext[etr_pkg::REMAIN_W-1:0];
      end
    end
  end

  // Distance from read index to write index, used to check the item count.
  logic [IDX_W:0] occupancy;
  assign occupancy = (write_index >= read_index)
                   ? {1'b0, write_index} - {1'b0, read_index}
                   : {1'b0, write_index} + (IDX_W+1)'(RING_DEPTH) - {1'b0, read_index};

  assert property (@(posedge clk) disable iff (rst)
    {1'b0, item_count} == occupancy)
    else $error("item count disagrees with ring indices");

  assert property (@(posedge clk) disable iff (rst)
    (write_index <= LAST_SLOT) && (read_index <= LAST_SLOT))
    else $error("ring index out of range");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !ram_we && (!out_valid || out_ready))
    else $error("result loaded over a waiting result or during a write");

endmodule

`default_nettype wire

>>> hw/rtl/event_trace_ring_buffer.sv
// Top level of the event trace ring buffer: controller plus datapath.
// Depends on etr_pkg, the three channel interfaces, etr_ctrl and etr_datapath.
//
//   Channel   Modport   Carries
//   item      sink      cmd, raw_time, event_code, event_param
//   result    source    out_timestamp, out_event, out_param, out_empty, out_remaining
//   cfg       sink      index, data (time offset, wrap code, marker code)
//
// A log request is accepted, then one entry RAM write is made per stored entry,
// in ST_WR_WRAP for a time-wrap entry, which is stored first, then in ST_WR_EVENT.
// A read request is accepted, then the registered RAM read feeds the output
// register; the load waits in ST_RD_RESULT while a previous result is held.
// The output register lets a new request be accepted while a result waits.
// rst is synchronous; it resets indices, counters, config registers and out_valid, not the RAM or the data registers.
`default_nettype none

module event_trace_ring_buffer #(
  parameter int RING_DEPTH = etr_pkg::RING_DEPTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  etr_item_if.sink    item,
  etr_result_if.source result,
  etr_cfg_if.sink     cfg
);

  etr_pkg::ctrl_cmd_t  ctrl_cmd;
  etr_pkg::dp_status_t dp_status;

  etr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  etr_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_cmd         (item.cmd),
    .in_raw_time    (item.raw_time),
    .in_event_code  (item.event_code),
    .in_event_param (item.event_param),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_timestamp  (result.out_timestamp),
    .out_event      (result.out_event),
    .out_param      (result.out_param),
    .out_empty      (result.out_empty),
    .out_remaining  (result.out_remaining),
    .cmd            (ctrl_cmd),
    .status         (dp_status)
  );

endmodule

`default_nettype wire
